### rtl/nla_pkg.sv
// shared constants and types of the newline line assembler
package nla_pkg;

  localparam int LINE_STORE_DEPTH = 64;
  localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);
  localparam int CHAR_W = 8;
  localparam int POS_W = 6;
  localparam int OVF_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] LINE_LIMIT = ADDR_W'(LINE_STORE_DEPTH - 1);
  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  typedef enum logic [0:0] {
    CMD_DATA,
    CMD_EOL
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic [CHAR_W-1:0] data;
  } queue_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } back_state_t;

endpackage

### rtl/nla_ram.sv
// generic single-write, single-read ram with registered read data
module nla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nla_front.sv
// front end: takes received bytes, drops fillers and tags the rest
module nla_front (
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic [7:0]             rx_byte,
  output logic                   push_valid,
  input  logic                   push_ready,
  output nla_pkg::queue_item_t   push_item
);
  import nla_pkg::*;

  logic ignored;

  always_comb begin
    ignored = 1'b0;
    push_item.cmd = CMD_DATA;
    push_item.data = rx_byte;
    case (rx_byte) inside
      CH_NUL, CH_CR: ignored = 1'b1;
      CH_LF: push_item.cmd = CMD_EOL;
      default: push_item.cmd = CMD_DATA;
    endcase
  end

  // ignored bytes are taken without touching the queue
  assign rx_ready = push_ready;
  assign push_valid = rx_valid && !ignored;

endmodule

### rtl/nla_queue.sv
// short queue of classified items between front and back end
module nla_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  nla_pkg::queue_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output nla_pkg::queue_item_t pop_item
);
  import nla_pkg::*;

  queue_item_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/nla_back.sv
// back end: stores characters, counts overflows and plays out finished lines
module nla_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  nla_pkg::queue_item_t pop_item,
  output logic                 line_valid,
  input  logic                 line_ready,
  output logic [7:0]           line_char,
  output logic [5:0]           char_position,
  output logic [5:0]           line_length,
  output logic                 last_of_line,
  output logic [15:0]          overflow_total
);
  import nla_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [ADDR_W-1:0] fill;
  logic [ADDR_W-1:0] fill_next;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] pos_next;
  logic [OVF_W-1:0] ovf;
  logic [OVF_W-1:0] ovf_next;
  logic we;
  logic re;
  logic last;
  logic [CHAR_W-1:0] rdata;

  nla_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(LINE_STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(fill),
    .wdata(pop_item.data),
    .re   (re),
    .raddr(pos),
    .rdata(rdata)
  );

  assign last = (pos == fill - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      pos <= '0;
      ovf <= '0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      pos <= pos_next;
      ovf <= ovf_next;
    end
  end

  always_comb begin
    state_next = state;
    fill_next = fill;
    pos_next = pos;
    ovf_next = ovf;
    we = 1'b0;
    re = 1'b0;
    pop_ready = 1'b0;
    line_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_item.cmd == CMD_EOL) begin
            // newline on an empty store does nothing
            if (fill != '0) begin
              pos_next = '0;
              state_next = ST_READ;
            end
          end else if (fill < LINE_LIMIT) begin
            we = 1'b1;
            fill_next = fill + 1'b1;
          end else begin
            fill_next = '0;
            if (ovf != OVF_MAX) begin
              ovf_next = ovf + 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        re = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        line_valid = 1'b1;
        if (line_ready) begin
          if (last) begin
            fill_next = '0;
            state_next = ST_IDLE;
          end else begin
            pos_next = pos + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign line_char = rdata;
  assign char_position = POS_W'(pos);
  assign line_length = POS_W'(fill);
  assign last_of_line = last;
  assign overflow_total = ovf;

endmodule

### rtl/newline_line_assembler.sv
// Newline line assembler: collects received bytes into a line store and, on a
// newline, plays the held line out one character per item with its position,
// the line length, a last-of-line flag and the saturating count of lines lost
// to overflow. Zero bytes and carriage returns are dropped at the input and
// never reach the back end. The back end takes a stored byte, an overflow or a
// newline in its idle state; a newline on a non-empty store starts the line,
// and each character of a finished line is then read from the registered
// read port of the line store and shown, waiting there on line_ready. A
// two-item queue sits between input classification and the back end, so up
// to two stored or newline bytes are taken while a line is played out or a
// character waits on line_ready; once the queue is full, rx_ready stays low,
// dropped bytes included. No clearing pass follows reset; the store is only
// read below its fill count.
module newline_line_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        line_valid,
  input  logic        line_ready,
  output logic [7:0]  line_char,
  output logic [5:0]  char_position,
  output logic [5:0]  line_length,
  output logic        last_of_line,
  output logic [15:0] overflow_total
);
  import nla_pkg::*;

  queue_item_t push_item;
  queue_item_t pop_item;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  nla_front u_front (
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  nla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  nla_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .line_valid    (line_valid),
    .line_ready    (line_ready),
    .line_char     (line_char),
    .char_position (char_position),
    .line_length   (line_length),
    .last_of_line  (last_of_line),
    .overflow_total(overflow_total)
  );

endmodule
